@@ rtl/diff_drive_motor_frame_top_assert.svh @@
// Assertion macros for the differential drive motor frame block.
// Used by the checker module; no other dependencies.
`ifndef DIFF_DRIVE_MOTOR_FRAME_TOP_ASSERT_SVH
`define DIFF_DRIVE_MOTOR_FRAME_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DDMF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DDMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ddmf_pkg.sv @@
// Types and constants of the differential drive motor frame block.
// No dependencies; used by diff_drive_motor_frame_top.
package ddmf_pkg;

   localparam int unsigned VEL_W    = 16;
   localparam int unsigned RADIUS_W = 10;
   localparam int unsigned SEP_W    = 12;
   localparam int unsigned MAXSP_W  = 16;
   localparam int unsigned VTERM_W  = 28;
   localparam int unsigned WTERM_W  = 29;
   localparam int unsigned SUM_W    = 30;
   localparam int unsigned ABS_W    = 28;
   localparam int unsigned RPI_W    = 28;
   localparam int unsigned DEN_W    = 44;
   localparam int unsigned NUM_W    = 49;
   localparam int unsigned CMP_W    = 51;
   localparam int unsigned Q_W      = 7;
   localparam int unsigned DIV_STAGES = Q_W;
   localparam int unsigned LIM_SHIFT  = 14;
   localparam int unsigned CSR_AW     = 4;
   localparam int unsigned CSR_DW     = 32;

   localparam logic [17:0]        PI_Q16    = 18'd205887;
   localparam logic signed [11:0] V_SCALE   = 12'sd2000;
   localparam logic [6:0]         PCT_SCALE = 7'd100;
   localparam logic [20:0]        PCT_Q16   = 21'd1638400;
   localparam logic [6:0]         PCT_MAX   = 7'd100;
   localparam logic [7:0]         MAG_SPLIT = 8'd80;

   localparam logic [RADIUS_W-1:0] RST_RADIUS = 10'd50;
   localparam logic [SEP_W-1:0]    RST_SEP    = 12'd300;
   localparam logic [MAXSP_W-1:0]  RST_MAXSP  = 16'd2000;
   localparam logic                RST_ENABLE = 1'b1;

   localparam logic [7:0] HDR_SYNC  = 8'hFF;
   localparam logic [7:0] HDR_ADDR  = 8'h01;
   localparam logic [7:0] HDR_CMD   = 8'h04;
   localparam logic [7:0] HDR_PAD   = 8'h00;
   localparam logic [7:0] TRL_CHK   = 8'h5A;
   localparam logic [7:0] TRL_END   = 8'h88;

   typedef logic [3:0] byte_pos_type;
   localparam byte_pos_type POS_SYNC  = 4'd0;
   localparam byte_pos_type POS_ADDR  = 4'd1;
   localparam byte_pos_type POS_CMD   = 4'd2;
   localparam byte_pos_type POS_PAD0  = 4'd3;
   localparam byte_pos_type POS_PAD1  = 4'd4;
   localparam byte_pos_type POS_DIR_R = 4'd5;
   localparam byte_pos_type POS_DIR_L = 4'd6;
   localparam byte_pos_type POS_MAG_R = 4'd7;
   localparam byte_pos_type POS_MAG_L = 4'd8;
   localparam byte_pos_type POS_CHK   = 4'd9;
   localparam byte_pos_type POS_END   = 4'd10;

   typedef enum logic [1:0] {
      DIR_FWD  = 2'd0,
      DIR_BACK = 2'd1,
      DIR_STOP = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      REG_RADIUS = 2'd0,
      REG_SEP    = 2'd1,
      REG_MAXSP  = 2'd2,
      REG_ENABLE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic                        en;
      logic signed [VTERM_W-1:0]   v_term;
      logic signed [WTERM_W-1:0]   w_term;
      logic [RPI_W-1:0]            rpi;
      logic [MAXSP_W-1:0]          mx;
   } prod_type;

   typedef struct packed {
      logic                        en;
      logic signed [SUM_W-1:0]     ar;
      logic signed [SUM_W-1:0]     al;
      logic [DEN_W-1:0]            den;
   } sum_type;

   typedef struct packed {
      logic                        en;
      logic                        neg_r;
      logic                        neg_l;
      logic [ABS_W-1:0]            abs_r;
      logic [ABS_W-1:0]            abs_l;
      logic [DEN_W-1:0]            den;
   } mag_type;

   typedef struct packed {
      logic                        en;
      logic                        neg_r;
      logic                        neg_l;
      logic                        scale;
      logic [ABS_W-1:0]            abs_r;
      logic [ABS_W-1:0]            abs_l;
      logic [ABS_W-1:0]            fast;
      logic [DEN_W-1:0]            den;
   } sel_type;

   typedef struct packed {
      logic                        en;
      logic                        neg_r;
      logic                        neg_l;
      logic [NUM_W-1:0]            rem_r;
      logic [NUM_W-1:0]            rem_l;
      logic [DEN_W-1:0]            den;
      logic [Q_W-1:0]              q_r;
      logic [Q_W-1:0]              q_l;
   } div_type;

   typedef struct packed {
      logic                        en;
      logic                        neg_r;
      logic                        neg_l;
      logic [Q_W-1:0]              pct_r;
      logic [Q_W-1:0]              pct_l;
   } pct_type;

   typedef struct packed {
      dir_type                     dir_r;
      dir_type                     dir_l;
      logic [7:0]                  mag_r;
      logic [7:0]                  mag_l;
   } wheel_frame_type;

endpackage

@@ rtl/diff_drive_motor_frame_top.sv @@
// Differential drive motor framer: turns each velocity command (linear mm/s, angular
// mrad/s) into right/left wheel percents of max speed and emits an 11-byte motor frame,
// one byte per transaction on the rsp_ channel. Commands flow through a 14-stage pipeline
// (two multiply stages, abs/select stages, a 7-stage restoring divider giving one
// quotient bit per stage, two byte-forming stages), then a frame serializer register. The
// sustained rate is set by the byte-wide frame output, which takes 11 byte transactions
// per command; req_ready stays high while pipeline stages are free. Depends on ddmf_pkg.
module diff_drive_motor_frame_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_linear_velocity,
   input  logic signed [15:0]  req_angular_velocity,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_frame_byte,
   output logic                rsp_frame_last,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import ddmf_pkg::*;

   logic [RADIUS_W-1:0] radius_ff;
   logic [SEP_W-1:0]    sep_ff;
   logic [MAXSP_W-1:0]  maxsp_ff;
   logic                enable_ff;
   reg_index_type       csr_idx;

   logic      s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic      s1_load, s2_load, s3_load, s4_load;
   prod_type  s1_ff, s1_in;
   sum_type   s2_ff, s2_in;
   mag_type   s3_ff, s3_in;
   sel_type   s4_ff, s4_in;

   logic      div_valid_ff [0:DIV_STAGES];
   logic      div_load     [0:DIV_STAGES];
   div_type   div_ff       [0:DIV_STAGES];
   div_type   div_in       [0:DIV_STAGES];

   logic      p_valid_ff, p_load;
   pct_type   p_ff, p_in;
   logic      f_valid_ff, f_load;
   wheel_frame_type f_ff, f_in;

   logic            ser_valid_ff, ser_load;
   wheel_frame_type ser_ff;
   byte_pos_type    ser_cnt_ff;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RST_RADIUS;
         sep_ff    <= RST_SEP;
         maxsp_ff  <= RST_MAXSP;
         enable_ff <= RST_ENABLE;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_idx)
            REG_RADIUS: radius_ff <= csr_pwdata[RADIUS_W-1:0];
            REG_SEP:    sep_ff    <= csr_pwdata[SEP_W-1:0];
            REG_MAXSP:  maxsp_ff  <= csr_pwdata[MAXSP_W-1:0];
            REG_ENABLE: enable_ff <= csr_pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_RADIUS: csr_prdata = CSR_DW'(radius_ff);
         REG_SEP:    csr_prdata = CSR_DW'(sep_ff);
         REG_MAXSP:  csr_prdata = CSR_DW'(maxsp_ff);
         REG_ENABLE: csr_prdata = CSR_DW'(enable_ff);
      endcase
   end

   // stall chain
   assign ser_load = !ser_valid_ff || (rsp_ready && ser_cnt_ff == POS_END);
   assign f_load   = !f_valid_ff || ser_load;
   assign p_load   = !p_valid_ff || f_load;
   assign div_load[DIV_STAGES] = !div_valid_ff[DIV_STAGES] || p_load;
   assign div_load[0] = !div_valid_ff[0] || div_load[1];
   assign s4_load  = !s4_valid_ff || div_load[0];
   assign s3_load  = !s3_valid_ff || s4_load;
   assign s2_load  = !s2_valid_ff || s3_load;
   assign s1_load  = !s1_valid_ff || s2_load;
   assign req_ready = s1_load;

   // stage 1: scale terms, radius * pi
   always_comb begin
      s1_in.en     = enable_ff;
      s1_in.v_term = req_linear_velocity * V_SCALE;
      s1_in.w_term = req_angular_velocity * $signed({1'b0, sep_ff});
      s1_in.rpi    = ((radius_ff == '0) ? RADIUS_W'(1) : radius_ff) * PI_Q16;
      s1_in.mx     = (maxsp_ff == '0) ? MAXSP_W'(1) : maxsp_ff;
   end

   // stage 2: wheel surface speeds, full denominator
   always_comb begin
      s2_in.en  = s1_ff.en;
      s2_in.ar  = SUM_W'(s1_ff.v_term) + SUM_W'(s1_ff.w_term);
      s2_in.al  = SUM_W'(s1_ff.v_term) - SUM_W'(s1_ff.w_term);
      s2_in.den = s1_ff.rpi * s1_ff.mx;
   end

   // stage 3: magnitudes
   always_comb begin
      s3_in.en    = s2_ff.en;
      s3_in.neg_r = s2_ff.ar[SUM_W-1];
      s3_in.neg_l = s2_ff.al[SUM_W-1];
      s3_in.abs_r = s2_ff.ar[SUM_W-1] ? ABS_W'(-s2_ff.ar) : ABS_W'(s2_ff.ar);
      s3_in.abs_l = s2_ff.al[SUM_W-1] ? ABS_W'(-s2_ff.al) : ABS_W'(s2_ff.al);
      s3_in.den   = s2_ff.den;
   end

   // stage 4: faster wheel, over-limit test
   always_comb begin
      s4_in.en    = s3_ff.en;
      s4_in.neg_r = s3_ff.neg_r;
      s4_in.neg_l = s3_ff.neg_l;
      s4_in.abs_r = s3_ff.abs_r;
      s4_in.abs_l = s3_ff.abs_l;
      s4_in.fast  = (s3_ff.abs_r >= s3_ff.abs_l) ? s3_ff.abs_r : s3_ff.abs_l;
      s4_in.scale = (DEN_W'({s3_ff.abs_r, {LIM_SHIFT{1'b0}}}) > s3_ff.den) ||
                    (DEN_W'({s3_ff.abs_l, {LIM_SHIFT{1'b0}}}) > s3_ff.den);
      s4_in.den   = s3_ff.den;
   end

   // stage 5: dividend and divisor
   always_comb begin
      div_in[0].en    = s4_ff.en;
      div_in[0].neg_r = s4_ff.neg_r;
      div_in[0].neg_l = s4_ff.neg_l;
      div_in[0].q_r   = '0;
      div_in[0].q_l   = '0;
      if (s4_ff.scale) begin
         div_in[0].rem_r = NUM_W'(s4_ff.abs_r) * NUM_W'(PCT_SCALE);
         div_in[0].rem_l = NUM_W'(s4_ff.abs_l) * NUM_W'(PCT_SCALE);
         div_in[0].den   = DEN_W'(s4_ff.fast);
      end else begin
         div_in[0].rem_r = NUM_W'(s4_ff.abs_r) * NUM_W'(PCT_Q16);
         div_in[0].rem_l = NUM_W'(s4_ff.abs_l) * NUM_W'(PCT_Q16);
         div_in[0].den   = s4_ff.den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         div_valid_ff[0] <= 1'b0;
      end else begin
         if (s1_load) s1_valid_ff <= req_valid;
         if (s2_load) s2_valid_ff <= s1_valid_ff;
         if (s3_load) s3_valid_ff <= s2_valid_ff;
         if (s4_load) s4_valid_ff <= s3_valid_ff;
         if (div_load[0]) div_valid_ff[0] <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) s1_ff <= s1_in;
      if (s2_load) s2_ff <= s2_in;
      if (s3_load) s3_ff <= s3_in;
      if (s4_load) s4_ff <= s4_in;
      if (div_load[0]) div_ff[0] <= div_in[0];
   end

   // restoring divider, one quotient bit per stage, MSB first
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      localparam int unsigned SH = DIV_STAGES - 1 - k;
      logic [CMP_W-1:0] dsh;
      logic             take_r, take_l;

      assign dsh    = CMP_W'(div_ff[k].den) << SH;
      assign take_r = CMP_W'(div_ff[k].rem_r) >= dsh;
      assign take_l = CMP_W'(div_ff[k].rem_l) >= dsh;

      always_comb begin
         div_in[k+1]     = div_ff[k];
         div_in[k+1].q_r = {div_ff[k].q_r[Q_W-2:0], take_r};
         div_in[k+1].q_l = {div_ff[k].q_l[Q_W-2:0], take_l};
         if (take_r) div_in[k+1].rem_r = NUM_W'(CMP_W'(div_ff[k].rem_r) - dsh);
         if (take_l) div_in[k+1].rem_l = NUM_W'(CMP_W'(div_ff[k].rem_l) - dsh);
      end

      if (k + 1 < DIV_STAGES) begin : g_ld
         assign div_load[k+1] = !div_valid_ff[k+1] || div_load[k+2];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[k+1] <= 1'b0;
         end else if (div_load[k+1]) begin
            div_valid_ff[k+1] <= div_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (div_load[k+1]) div_ff[k+1] <= div_in[k+1];
      end
   end

   // floor for negative speeds: round magnitude up on nonzero remainder
   logic [7:0] sum_r, sum_l;
   always_comb begin
      sum_r = {1'b0, div_ff[DIV_STAGES].q_r} +
              8'(div_ff[DIV_STAGES].neg_r && div_ff[DIV_STAGES].rem_r != '0);
      sum_l = {1'b0, div_ff[DIV_STAGES].q_l} +
              8'(div_ff[DIV_STAGES].neg_l && div_ff[DIV_STAGES].rem_l != '0);
      p_in.en    = div_ff[DIV_STAGES].en;
      p_in.neg_r = div_ff[DIV_STAGES].neg_r;
      p_in.neg_l = div_ff[DIV_STAGES].neg_l;
      p_in.pct_r = (sum_r > 8'(PCT_MAX)) ? PCT_MAX : sum_r[Q_W-1:0];
      p_in.pct_l = (sum_l > 8'(PCT_MAX)) ? PCT_MAX : sum_l[Q_W-1:0];
   end

   // direction and magnitude bytes
   logic stop_r, stop_l;
   always_comb begin
      stop_r = !p_ff.en || (p_ff.pct_r == '0);
      stop_l = !p_ff.en || (p_ff.pct_l == '0);
      f_in.dir_r = stop_r ? DIR_STOP : (p_ff.neg_r ? DIR_BACK : DIR_FWD);
      f_in.dir_l = stop_l ? DIR_STOP : (p_ff.neg_l ? DIR_BACK : DIR_FWD);
      f_in.mag_r = stop_r ? 8'd0 : 8'(p_ff.pct_r);
      f_in.mag_l = stop_l ? 8'd0 : 8'(p_ff.pct_l);
      if (f_in.dir_r != f_in.dir_l) begin
         f_in.mag_r = f_in.mag_r + MAG_SPLIT;
         f_in.mag_l = f_in.mag_l + MAG_SPLIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         if (p_load) p_valid_ff <= div_valid_ff[DIV_STAGES];
         if (f_load) f_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p_load) p_ff <= p_in;
      if (f_load) f_ff <= f_in;
   end

   // frame serializer
   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         ser_cnt_ff   <= POS_SYNC;
      end else if (ser_load) begin
         ser_valid_ff <= f_valid_ff;
         ser_cnt_ff   <= POS_SYNC;
      end else if (rsp_ready) begin
         ser_cnt_ff   <= ser_cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) ser_ff <= f_ff;
   end

   assign rsp_valid      = ser_valid_ff;
   assign rsp_frame_last = (ser_cnt_ff == POS_END);

   always_comb begin
      unique case (ser_cnt_ff)
         POS_SYNC:  rsp_frame_byte = HDR_SYNC;
         POS_ADDR:  rsp_frame_byte = HDR_ADDR;
         POS_CMD:   rsp_frame_byte = HDR_CMD;
         POS_PAD0:  rsp_frame_byte = HDR_PAD;
         POS_PAD1:  rsp_frame_byte = HDR_PAD;
         POS_DIR_R: rsp_frame_byte = {6'd0, ser_ff.dir_r};
         POS_DIR_L: rsp_frame_byte = {6'd0, ser_ff.dir_l};
         POS_MAG_R: rsp_frame_byte = ser_ff.mag_r;
         POS_MAG_L: rsp_frame_byte = ser_ff.mag_l;
         POS_CHK:   rsp_frame_byte = TRL_CHK;
         POS_END:   rsp_frame_byte = TRL_END;
         default:   rsp_frame_byte = HDR_PAD;
      endcase
   end

endmodule

@@ rtl/ddmf_checker.sv @@
// Port-level checker for diff_drive_motor_frame_top, bound to the top level.
// Depends on diff_drive_motor_frame_top_assert.svh.
`include "diff_drive_motor_frame_top_assert.svh"

module ddmf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_frame_last
);

   `DDMF_ASSERT_SAME(a_last_is_end, clock, reset, rsp_valid && rsp_frame_last, rsp_frame_byte == 8'h88, "last byte of frame is not 0x88")

   `DDMF_ASSERT_NEXT(a_new_frame_sync, clock, reset, rsp_valid && rsp_ready && rsp_frame_last, !rsp_valid || rsp_frame_byte == 8'hFF, "frame does not start with 0xFF")

   `DDMF_ASSERT_NEXT(a_sync_then_addr, clock, reset, rsp_valid && rsp_ready && !rsp_frame_last && rsp_frame_byte == 8'hFF, rsp_valid && rsp_frame_byte == 8'h01, "frame broken after sync byte")

   `DDMF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_frame_last), "stalled transaction changed")

endmodule

bind diff_drive_motor_frame_top ddmf_checker u_ddmf_checker (.*);
